// File: src/fbpi_pkg.sv
// Shared types and constants for the FASTQ barcode prefix inserter.
package fbpi_pkg;

  localparam int PREFIX_LEN = 23;
  localparam int CODE_BASES = 16;
  localparam int TAG_LEN    = 12;

  localparam logic [4:0] PREFIX_LAST = 5'(PREFIX_LEN);
  localparam logic [3:0] TAG_COUNT   = 4'(TAG_LEN);
  localparam logic [7:0] BLANK_LIMIT = 8'd33;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_HASH  = 8'h23;

  localparam logic [7:0] BASE_TABLE [4] = '{8'h41, 8'h54, 8'h47, 8'h43};

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_TAG1  = 4'd1,
    MODE_TAG2  = 4'd2,
    MODE_TAG3  = 4'd3,
    MODE_TAG4  = 4'd4,
    MODE_TAG5  = 4'd5,
    MODE_CAPT  = 4'd6,
    MODE_GOT   = 4'd7,
    MODE_WSEQ  = 4'd8,
    MODE_SEQD  = 4'd9,
    MODE_SKP1  = 4'd10,
    MODE_WQUAL = 4'd11,
    MODE_SKP2  = 4'd12,
    MODE_SKP3  = 4'd13,
    MODE_DONE  = 4'd14
  } mode_t;

  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_SEQ  = 2'd1,
    RUN_QUAL = 2'd2
  } run_kind_t;

  typedef struct packed {
    logic [7:0]  ch;
    run_kind_t   kind;
    logic [31:0] code;
    logic        code_zero;
  } job_t;

endpackage

// File: src/fbpi_parser.sv
// Input register, header parser state machine and barcode packing.
module fbpi_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_char,
  output logic          job_valid,
  output fbpi_pkg::job_t job,
  input  logic          job_ready
);
  import fbpi_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_char_r;
  mode_t       mode_r, mode_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [31:0] code_r, code_nxt;
  logic [7:0]  capt_r [TAG_LEN];
  logic        capt_we;
  logic [31:0] packed_code;
  logic        pair_zero;
  logic        advance;
  mode_t       m;
  logic [7:0]  c;

  // Pair value (a-'0')*10+(b-'0') in 32-bit two's complement.
  function automatic logic [31:0] pair_val(input logic [7:0] a, input logic [7:0] b);
    logic [11:0] v;
    v = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {4'b0000, b};
    return {20'd0, v} - 32'd528;
  endfunction

  assign advance   = in_valid_r && job_ready;
  assign in_stall  = in_valid_r && !job_ready;
  assign job_valid = in_valid_r;
  assign c         = in_char_r;

  always_comb begin
    pair_zero = (capt_r[1] == CH_ZERO && capt_r[2] == CH_ZERO) ||
                (capt_r[4] == CH_ZERO && capt_r[5] == CH_ZERO) ||
                (capt_r[7] == CH_ZERO && capt_r[8] == CH_ZERO) ||
                (capt_r[10] == CH_ZERO && capt_r[11] == CH_ZERO);
    packed_code = pair_zero ? 32'd0 :
                  ((pair_val(capt_r[1], capt_r[2]) << 24) |
                   (pair_val(capt_r[4], capt_r[5]) << 16) |
                   (pair_val(capt_r[7], capt_r[8]) << 8) |
                   pair_val(capt_r[10], capt_r[11]));
  end

  always_comb begin
    m         = mode_r;
    count_nxt = count_r;
    code_nxt  = code_r;
    capt_we   = 1'b0;
    job.ch        = c;
    job.kind      = RUN_NONE;
    job.code      = code_r;
    job.code_zero = (code_r == 32'd0);

    // Tag recognition on the header line.
    unique case (mode_r)
      MODE_IDLE: if (c < BLANK_LIMIT) m = MODE_TAG1;
      MODE_TAG1: m = (c == CH_B) ? MODE_TAG2 : MODE_IDLE;
      MODE_TAG2: m = (c == CH_X) ? MODE_TAG3 : MODE_IDLE;
      MODE_TAG3: m = (c == CH_COLON) ? MODE_TAG4 : MODE_IDLE;
      MODE_TAG4: m = (c == CH_Z) ? MODE_TAG5 : MODE_IDLE;
      MODE_TAG5: begin
        m = (c == CH_COLON) ? MODE_CAPT : MODE_IDLE;
        count_nxt = 4'd0;
      end
      MODE_CAPT: begin
        if (c < BLANK_LIMIT) begin
          m = (count_r == TAG_COUNT) ? MODE_GOT : MODE_IDLE;
        end else begin
          capt_we   = (count_r < TAG_COUNT);
          count_nxt = count_r + 4'd1;
          if (count_nxt > TAG_COUNT) m = MODE_IDLE;
        end
      end
      default: ;
    endcase

    // Line tracking through sequence, plus and quality lines.
    if (c == CH_NL) begin
      unique case (m)
        MODE_DONE: m = MODE_IDLE;
        MODE_SKP3: m = MODE_DONE;
        MODE_SKP2: m = MODE_SKP3;
        MODE_SKP1: m = MODE_WQUAL;
        MODE_SEQD: m = MODE_SKP1;
        MODE_GOT:  m = MODE_WSEQ;
        default:   m = MODE_SKP2;
      endcase
    end else if (m == MODE_WSEQ) begin
      code_nxt      = packed_code;
      job.kind      = RUN_SEQ;
      job.code      = packed_code;
      job.code_zero = (packed_code == 32'd0);
      m = MODE_SEQD;
    end else if (m == MODE_WQUAL) begin
      job.kind = RUN_QUAL;
      m = MODE_DONE;
    end
    mode_nxt = m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      mode_r     <= MODE_IDLE;
      count_r    <= 4'd0;
      code_r     <= 32'd0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        mode_r  <= mode_nxt;
        count_r <= count_nxt;
        code_r  <= code_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_char_r <= in_char;
    end
    if (advance && capt_we) begin
      capt_r[count_r] <= c;
    end
  end

endmodule

// File: src/fbpi_emitter.sv
// Result register that plays out a prefix run and then the echoed byte.
module fbpi_emitter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  fbpi_pkg::job_t job,
  output logic          job_ready,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic          out_run_last
);
  import fbpi_pkg::*;

  logic        valid_r;
  logic [4:0]  count_r;
  logic [7:0]  ch_r;
  run_kind_t   kind_r;
  logic [31:0] code_r;
  logic        zero_r;
  logic        last;
  logic        xfer;

  assign last         = (count_r == PREFIX_LAST);
  assign xfer         = valid_r && !out_stall;
  assign job_ready    = !valid_r || (last && !out_stall);
  assign out_valid    = valid_r;
  assign out_run_last = last;

  always_comb begin
    if (last) begin
      out_char = ch_r;
    end else if (kind_r == RUN_QUAL) begin
      out_char = zero_r ? CH_HASH : CH_J;
    end else if (zero_r) begin
      out_char = CH_N;
    end else if (count_r < 5'(CODE_BASES)) begin
      out_char = BASE_TABLE[code_r[31:30]];
    end else begin
      out_char = CH_A;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= PREFIX_LAST;
    end else if (job_ready) begin
      valid_r <= job_valid;
      if (job_valid) begin
        count_r <= (job.kind == RUN_NONE) ? PREFIX_LAST : 5'd0;
      end
    end else if (xfer) begin
      count_r <= count_r + 5'd1;
    end
  end

  // The code shifts up two bits per base so the next base is always on top.
  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      ch_r   <= job.ch;
      kind_r <= job.kind;
      code_r <= job.code;
      zero_r <= job.code_zero;
    end else if (xfer && !last) begin
      code_r <= {code_r[29:0], 2'b00};
    end
  end

endmodule

// File: src/fastq_barcode_prefix_inserter.sv
// Top level of the FASTQ barcode prefix inserter.
// The input channel (in_valid, in_stall, in_char) takes one byte of FASTQ
// text per transfer. The result channel (out_valid, out_stall, out_char,
// out_run_last) gives every input byte back with out_run_last high, and
// for a read whose header carries a 12-character BX:Z: tag it first gives
// a 23-byte run: the barcode as 16 bases and 7 'A' before the sequence
// line, 23 'J' before the quality line ('N' and '#' when the code is zero).
// A byte is held in an input register and parsed on its way into the
// result register. The block sustains one byte per cycle while bytes
// carry no run and out_stall is low. While the result register plays
// out a run, one result byte per cycle unless out_stall holds it, it
// takes no new byte, and in_stall rises once the next byte waits.
// When the receiver raises out_stall the result register holds, the input
// register fills and then in_stall follows. Reset (rst_n low at a clock
// edge) empties both registers and returns the parser to its idle state.
module fastq_barcode_prefix_inserter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_run_last
);
  import fbpi_pkg::*;

  logic job_valid;
  logic job_ready;
  job_t job;

  fbpi_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_char   (in_char),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  fbpi_emitter u_emitter (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job_valid),
    .job          (job),
    .job_ready    (job_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

endmodule
